// ===== design/memory_pattern_search_macros.svh =====
// Assertion macros shared by the memory pattern search design.
`ifndef MEMORY_PATTERN_SEARCH_MACROS_SVH
`define MEMORY_PATTERN_SEARCH_MACROS_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define MPS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("memory_pattern_search: same-cycle check failed");

// Next-cycle implication, sampled on clk, off during reset.
`define MPS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("memory_pattern_search: next-cycle check failed");

`endif

// ===== design/mps_pkg.sv =====
// Types, constants and helper functions for the memory pattern search block.
package mps_pkg;

	localparam int ADDR_BITS_DEF   = 16;
	localparam int MAX_PATTERN_DEF = 128;

	localparam int OPCODE_W  = 2;
	localparam int FADDR_W   = 16;
	localparam int BYTE_W    = 8;
	localparam int SLOT_W    = 7;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DAT_W = 8;

	localparam logic [OPCODE_W-1:0] OP_MEM_WRITE = 2'd0;
	localparam logic [OPCODE_W-1:0] OP_PAT_WRITE = 2'd1;
	localparam logic [OPCODE_W-1:0] OP_SEARCH    = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MATCH_MODE     = 4'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_PATTERN_LENGTH = 4'd1;

	localparam logic MODE_EXACT = 1'b0;
	localparam logic MODE_TEXT  = 1'b1;

	localparam logic [BYTE_W-1:0] ASCII_MASK   = 8'h7F;
	localparam logic [BYTE_W-1:0] LOWER_FIRST  = 8'h61;
	localparam logic [BYTE_W-1:0] LOWER_LAST   = 8'h7A;
	localparam logic [BYTE_W-1:0] CASE_OFFSET  = 8'h20;

	typedef struct packed {
		logic [OPCODE_W-1:0] opcode;
		logic [FADDR_W-1:0]  mem_address;
		logic [BYTE_W-1:0]   mem_data;
		logic [SLOT_W-1:0]   pattern_slot;
		logic [BYTE_W-1:0]   pattern_value;
		logic [FADDR_W-1:0]  start_address;
	} in_t;

	typedef struct packed {
		logic               found;
		logic [FADDR_W-1:0] match_address;
	} out_t;

	typedef enum logic [1:0] {
		SCAN_IDLE,
		SCAN_SETUP,
		SCAN_RUN,
		SCAN_DONE
	} scan_state_t;

	typedef struct packed {
		logic start;
		logic mode;
	} scan_req_t;

	typedef struct packed {
		logic valid;
		logic found;
	} scan_res_t;

	function automatic logic [BYTE_W-1:0] fold_upper(input logic [BYTE_W-1:0] c);
		logic [BYTE_W-1:0] r;
		r = c;
		if (c >= LOWER_FIRST && c <= LOWER_LAST) begin
			r = c - CASE_OFFSET;
		end
		return r;
	endfunction

	function automatic logic byte_eq(input logic [BYTE_W-1:0] m, input logic [BYTE_W-1:0] p,
			input logic mode);
		logic eq;
		if (mode == MODE_TEXT) begin
			eq = (fold_upper(m & ASCII_MASK) == fold_upper(p));
		end else begin
			eq = (m == p);
		end
		return eq;
	endfunction

endpackage

// ===== design/mps_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
module mps_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

// ===== design/mps_scan.sv =====
// Scan sequencer: walks candidate addresses and compares one byte per cycle between mismatches.
module mps_scan #(
	parameter int ADDR_BITS   = mps_pkg::ADDR_BITS_DEF,
	parameter int MAX_PATTERN = mps_pkg::MAX_PATTERN_DEF,
	localparam int CNT_W  = $clog2(MAX_PATTERN + 1),
	localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  mps_pkg::scan_req_t         req,
	input  logic [CNT_W-1:0]           req_len,
	input  logic [ADDR_BITS:0]         req_begin,
	input  logic                       out_free,
	input  logic [mps_pkg::BYTE_W-1:0] mem_rdata,
	input  logic [mps_pkg::BYTE_W-1:0] pat_rdata,
	output logic                       busy,
	output logic [ADDR_BITS-1:0]       mem_raddr,
	output logic [PIDX_W-1:0]          pat_raddr,
	output mps_pkg::scan_res_t         res,
	output logic [ADDR_BITS-1:0]       res_addr
);

	localparam logic [ADDR_BITS:0] MEM_SIZE = (ADDR_BITS + 1)'(1) << ADDR_BITS;

	mps_pkg::scan_state_t state_q, state_d;

	logic                 mode_q;
	logic [CNT_W-1:0]     len_q;
	logic [ADDR_BITS:0]   begin_q;
	logic [ADDR_BITS-1:0] cand_q;
	logic [ADDR_BITS-1:0] end_q;
	logic [ADDR_BITS-1:0] end2_q;
	logic                 pass_q;
	logic [CNT_W-1:0]     idx_q;
	logic                 found_q;
	logic                 v_s1;
	logic [CNT_W-1:0]     idx_s1;

	logic [ADDR_BITS-1:0] limit;
	logic                 issue;
	logic                 mismatch;
	logic                 hit;
	logic                 at_end;

	assign limit    = ADDR_BITS'(MEM_SIZE - (ADDR_BITS + 1)'(len_q));
	assign issue    = idx_q < len_q;
	assign mismatch = v_s1 && !mps_pkg::byte_eq(mem_rdata, pat_rdata, mode_q);
	assign hit      = v_s1 && !mismatch && (idx_s1 == CNT_W'(len_q - 1'b1));
	assign at_end   = cand_q == end_q;

	assign mem_raddr = cand_q + ADDR_BITS'(idx_q);
	assign pat_raddr = PIDX_W'(idx_q);
	assign res_addr  = cand_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= mps_pkg::SCAN_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		busy      = 1'b1;
		res.valid = 1'b0;
		res.found = found_q;
		unique case (state_q)
			mps_pkg::SCAN_IDLE: begin
				busy = 1'b0;
				if (req.start) begin
					state_d = mps_pkg::SCAN_SETUP;
				end
			end
			mps_pkg::SCAN_SETUP: begin
				state_d = mps_pkg::SCAN_RUN;
			end
			mps_pkg::SCAN_RUN: begin
				if (hit || (mismatch && at_end && pass_q)) begin
					state_d = mps_pkg::SCAN_DONE;
				end
			end
			mps_pkg::SCAN_DONE: begin
				if (out_free) begin
					res.valid = 1'b1;
					state_d   = mps_pkg::SCAN_IDLE;
				end
			end
			default: begin
				state_d = mps_pkg::SCAN_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			pass_q  <= 1'b0;
			found_q <= 1'b0;
			idx_q   <= '0;
		end else begin
			unique case (state_q)
				mps_pkg::SCAN_IDLE: begin
					v_s1 <= 1'b0;
				end
				mps_pkg::SCAN_SETUP: begin
					idx_q <= '0;
					v_s1  <= 1'b0;
					if (begin_q > (ADDR_BITS + 1)'(limit)) begin
						pass_q <= 1'b1;
					end else begin
						pass_q <= 1'b0;
					end
				end
				mps_pkg::SCAN_RUN: begin
					if (hit) begin
						found_q <= 1'b1;
						v_s1    <= 1'b0;
					end else if (mismatch) begin
						v_s1  <= 1'b0;
						idx_q <= '0;
						if (at_end) begin
							if (!pass_q) begin
								pass_q <= 1'b1;
							end else begin
								found_q <= 1'b0;
							end
						end
					end else begin
						v_s1 <= issue;
						if (issue) begin
							idx_q <= idx_q + 1'b1;
						end
					end
				end
				default: begin
					v_s1 <= 1'b0;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		unique case (state_q)
			mps_pkg::SCAN_IDLE: begin
				if (req.start) begin
					mode_q  <= req.mode;
					len_q   <= req_len;
					begin_q <= req_begin;
				end
			end
			mps_pkg::SCAN_SETUP: begin
				end2_q <= (begin_q < (ADDR_BITS + 1)'(limit)) ? ADDR_BITS'(begin_q) : limit;
				end_q  <= limit;
				if (begin_q > (ADDR_BITS + 1)'(limit)) begin
					cand_q <= '0;
				end else begin
					cand_q <= ADDR_BITS'(begin_q);
				end
			end
			mps_pkg::SCAN_RUN: begin
				if (!v_s1 || !hit) begin
					if (issue && !mismatch) begin
						idx_s1 <= idx_q;
					end
				end
				if (mismatch && !hit) begin
					if (at_end) begin
						if (!pass_q) begin
							cand_q <= '0;
							end_q  <= end2_q;
						end
					end else begin
						cand_q <= cand_q + 1'b1;
					end
				end
			end
			default: begin
				mode_q <= mode_q;
			end
		endcase
	end

endmodule

// ===== design/memory_pattern_search.sv =====
// Top level of the memory pattern search block: ports, loads, result register.
//
//  channel | direction | handshake            | payload
//  --------+-----------+----------------------+------------------------------
//  in      | in        | in_valid / in_stall  | in_data  (mps_pkg::in_t)
//  out     | out       | out_valid / out_stall| out_data (mps_pkg::out_t)
//  cfg     | in        | cfg_valid / cfg_ready| cfg_index, cfg_data
//
//  Memory and pattern writes are taken back to back.
//  A search runs a setup state, then compares each candidate address byte by byte;
//  the byte memory's single read port sets one compared byte a cycle.
//  Reset clears control and the remembered match; the byte and pattern memories
//  are not cleared. Loads are taken while a result waits in the out register;
//  a finished search holds until that register frees up.
module memory_pattern_search #(
	parameter int ADDR_BITS   = mps_pkg::ADDR_BITS_DEF,
	parameter int MAX_PATTERN = mps_pkg::MAX_PATTERN_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  mps_pkg::in_t                  in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output mps_pkg::out_t                 out_data,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [mps_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [mps_pkg::CFG_DAT_W-1:0] cfg_data
);

	localparam int CNT_W  = $clog2(MAX_PATTERN + 1);
	localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	logic                         mode_q;
	logic [mps_pkg::CFG_DAT_W-1:0] plen_q;
	logic                         last_valid_q;
	logic [ADDR_BITS-1:0]         last_addr_q;
	logic                         out_valid_q;
	mps_pkg::out_t                out_q;

	logic                         busy;
	logic                         accept;
	logic                         mem_we;
	logic                         pat_we;
	logic                         search_go;
	logic                         out_free;
	logic [CNT_W-1:0]             eff_len;
	logic [ADDR_BITS:0]           scan_begin;
	logic [ADDR_BITS-1:0]         mem_raddr;
	logic [PIDX_W-1:0]            pat_raddr;
	logic [mps_pkg::BYTE_W-1:0]   mem_rdata;
	logic [mps_pkg::BYTE_W-1:0]   pat_rdata;
	logic [ADDR_BITS-1:0]         res_addr;
	mps_pkg::scan_req_t           req;
	mps_pkg::scan_res_t           res;

	assign in_stall  = busy;
	assign cfg_ready = 1'b1;
	assign accept    = in_valid && !in_stall;
	assign out_free  = !out_valid_q || !out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	assign mem_we    = accept && (in_data.opcode == mps_pkg::OP_MEM_WRITE);
	assign pat_we    = accept && (in_data.opcode == mps_pkg::OP_PAT_WRITE)
		&& (32'(in_data.pattern_slot) < 32'(MAX_PATTERN));
	assign search_go = accept && (in_data.opcode == mps_pkg::OP_SEARCH) && (plen_q != '0);

	assign eff_len = (32'(plen_q) > 32'(MAX_PATTERN)) ? CNT_W'(MAX_PATTERN) : CNT_W'(plen_q);
	assign scan_begin = last_valid_q ? ((ADDR_BITS + 1)'(last_addr_q) + 1'b1)
		: (ADDR_BITS + 1)'(ADDR_BITS'(in_data.start_address));

	assign req.start = search_go;
	assign req.mode  = mode_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= mps_pkg::MODE_EXACT;
			plen_q <= mps_pkg::CFG_DAT_W'(1);
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				mps_pkg::CFG_MATCH_MODE: begin
					mode_q <= cfg_data[0];
				end
				mps_pkg::CFG_PATTERN_LENGTH: begin
					plen_q <= cfg_data;
				end
				default: begin
					plen_q <= plen_q;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_valid_q <= 1'b0;
			last_addr_q  <= '0;
			out_valid_q  <= 1'b0;
		end else if (res.valid) begin
			last_valid_q <= res.found;
			last_addr_q  <= res.found ? res_addr : '0;
			out_valid_q  <= 1'b1;
		end else if (out_valid_q && !out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (res.valid) begin
			out_q.found         <= res.found;
			out_q.match_address <= res.found ? mps_pkg::FADDR_W'(res_addr) : '0;
		end
	end

	mps_ram #(
		.WIDTH (mps_pkg::BYTE_W),
		.DEPTH (1 << ADDR_BITS)
	) u_mem (
		.clk   (clk),
		.we    (mem_we),
		.waddr (ADDR_BITS'(in_data.mem_address)),
		.wdata (in_data.mem_data),
		.raddr (mem_raddr),
		.rdata (mem_rdata)
	);

	mps_ram #(
		.WIDTH (mps_pkg::BYTE_W),
		.DEPTH (MAX_PATTERN)
	) u_pat (
		.clk   (clk),
		.we    (pat_we),
		.waddr (PIDX_W'(in_data.pattern_slot)),
		.wdata (in_data.pattern_value),
		.raddr (pat_raddr),
		.rdata (pat_rdata)
	);

	mps_scan #(
		.ADDR_BITS   (ADDR_BITS),
		.MAX_PATTERN (MAX_PATTERN)
	) u_scan (
		.clk       (clk),
		.arst_n    (arst_n),
		.req       (req),
		.req_len   (eff_len),
		.req_begin (scan_begin),
		.out_free  (out_free),
		.mem_rdata (mem_rdata),
		.pat_rdata (pat_rdata),
		.busy      (busy),
		.mem_raddr (mem_raddr),
		.pat_raddr (pat_raddr),
		.res       (res),
		.res_addr  (res_addr)
	);

`include "memory_pattern_search_macros.svh"

	`MPS_ASSERT_NOW(a_res_needs_free_out, res.valid, out_free)
	`MPS_ASSERT_NEXT(a_search_blocks_input, search_go, in_stall)
	`MPS_ASSERT_NEXT(a_match_remembered_with_result, res.valid && res.found,
		last_valid_q && out_valid && out_data.found)

endmodule

// ===== tb/sv/tb_top.sv =====
// Self-checking testbench for memory_pattern_search: load, search and compare against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [mps_pkg::OPCODE_W-1:0] OP_UNUSED = 2'd3;
	localparam int MEM_BYTES     = 65536;
	localparam int PAT_SLOTS     = 128;
	localparam int SETTLE_CYCLES = 16;
	localparam int QUIET_LIMIT   = 700000;
	localparam int SEGMENT_ITEMS = 75;

	logic                          clk       = 1'b0;
	logic                          arst_n    = 1'b0;
	logic                          in_valid  = 1'b0;
	logic                          in_stall;
	mps_pkg::in_t                  in_data   = '0;
	logic                          out_valid;
	logic                          out_stall = 1'b0;
	mps_pkg::out_t                 out_data;
	logic                          cfg_valid = 1'b0;
	logic                          cfg_ready;
	logic [mps_pkg::CFG_IDX_W-1:0] cfg_index = '0;
	logic [mps_pkg::CFG_DAT_W-1:0] cfg_data  = '0;

	memory_pattern_search u_top (.*);

	// predictor state
	logic [7:0]  mem_img [MEM_BYTES];
	logic [7:0]  pat_img [PAT_SLOTS];
	logic        mode_reg    = mps_pkg::MODE_EXACT;
	logic [7:0]  pat_len_reg = 8'd1;
	logic        hit_valid   = 1'b0;
	logic [15:0] hit_addr    = '0;

	mps_pkg::in_t  items_to_send[$];
	mps_pkg::out_t search_answers[$];
	int   send_idle_pct  = 0;
	int   recv_idle_pct  = 0;
	int   mismatch_count = 0;
	int   useful_items   = 0;

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic logic [7:0] upcase(input logic [7:0] c);
		return (c >= 8'h61 && c <= 8'h7A) ? c - 8'h20 : c;
	endfunction

	function automatic int pattern_span();
		return (int'(pat_len_reg) > PAT_SLOTS) ? PAT_SLOTS : int'(pat_len_reg);
	endfunction

	function automatic logic window_matches(input int at, input int n);
		logic [7:0] m;
		logic [7:0] p;
		for (int i = 0; i < n; i++) begin
			m = mem_img[16'(at + i)];
			p = pat_img[7'(i)];
			if (mode_reg == mps_pkg::MODE_TEXT) begin
				m = upcase(m & 8'h7F);
				p = upcase(p);
			end
			if (m != p) return 1'b0;
		end
		return 1'b1;
	endfunction

	function automatic void expect_answer(input mps_pkg::out_t ans);
		search_answers.insert(search_answers.size(), ans);
	endfunction

	function automatic void scan_for_pattern(input logic [15:0] start);
		int   n;
		int   first;
		int   limit;
		int   lo;
		int   hi;
		mps_pkg::out_t ans;
		n = pattern_span();
		if (n == 0) return;
		first = hit_valid ? int'(hit_addr) + 1 : int'(start);
		limit = MEM_BYTES - n;
		for (int pass = 0; pass < 2; pass++) begin
			lo = (pass == 0) ? first : 0;
			hi = (pass == 0) ? limit : ((first < limit) ? first : limit);
			for (int a = lo; a <= hi; a++) begin
				if (window_matches(a, n)) begin
					hit_valid = 1'b1;
					hit_addr = a[15:0];
					ans.found = 1'b1;
					ans.match_address = a[15:0];
					expect_answer(ans);
					return;
				end
			end
		end
		hit_valid = 1'b0;
		hit_addr = '0;
		ans = '0;
		expect_answer(ans);
	endfunction

	function automatic void absorb_item(input mps_pkg::in_t it);
		case (it.opcode)
			mps_pkg::OP_MEM_WRITE: mem_img[it.mem_address] = it.mem_data;
			mps_pkg::OP_PAT_WRITE: pat_img[it.pattern_slot] = it.pattern_value;
			mps_pkg::OP_SEARCH:    scan_for_pattern(it.start_address);
			default:      ;
		endcase
	endfunction

	task automatic note_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_count++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) absorb_item(in_data);
			if (!in_valid || !in_stall) begin
				if (items_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
					in_valid <= 1'b1;
					in_data <= items_to_send.pop_front();
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		mps_pkg::out_t ans;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (search_answers.size() == 0) begin
					note_mismatch($sformatf("unexpected result found=%0b addr=%h",
						out_data.found, out_data.match_address));
				end else begin
					ans = search_answers.pop_front();
					if (out_data.found !== ans.found)
						note_mismatch($sformatf("found %0b, wanted %0b", out_data.found, ans.found));
					if (out_data.match_address !== ans.match_address)
						note_mismatch($sformatf("match_address %h, wanted %h",
							out_data.match_address, ans.match_address));
				end
			end
			out_stall <= ($urandom_range(99) < recv_idle_pct);
		end
	end

	function automatic mps_pkg::in_t random_item(input logic [mps_pkg::OPCODE_W-1:0] op);
		mps_pkg::in_t it;
		it.opcode = op;
		it.mem_address = 16'($urandom_range(0, 65535));
		it.mem_data = 8'($urandom_range(0, 255));
		it.pattern_slot = 7'($urandom_range(0, 127));
		it.pattern_value = 8'($urandom_range(0, 255));
		it.start_address = 16'($urandom_range(0, 65535));
		return it;
	endfunction

	function automatic void send(input mps_pkg::in_t it);
		items_to_send.insert(items_to_send.size(), it);
		if (it.opcode != OP_UNUSED) useful_items++;
	endfunction

	function automatic void send_mem(input int addr, input int val);
		mps_pkg::in_t it;
		it = random_item(mps_pkg::OP_MEM_WRITE);
		it.mem_address = addr[15:0];
		it.mem_data = val[7:0];
		send(it);
	endfunction

	function automatic void send_pat(input int slot, input int val);
		mps_pkg::in_t it;
		it = random_item(mps_pkg::OP_PAT_WRITE);
		it.pattern_slot = slot[6:0];
		it.pattern_value = val[7:0];
		send(it);
	endfunction

	function automatic void send_search(input int start);
		mps_pkg::in_t it;
		it = random_item(mps_pkg::OP_SEARCH);
		it.start_address = start[15:0];
		send(it);
	endfunction

	function automatic logic [7:0] pattern_byte();
		if (mode_reg == mps_pkg::MODE_EXACT) return 8'($urandom_range(0, 255));
		if ($urandom_range(0, 1)) begin
			if ($urandom_range(0, 1)) return 8'($urandom_range(8'h41, 8'h5A));
			return 8'($urandom_range(8'h61, 8'h7A));
		end
		return 8'($urandom_range(0, 127));
	endfunction

	// memory image of a pattern byte; in text mode flips case and sets bit 7 at random
	function automatic logic [7:0] disguise(input logic [7:0] p);
		logic [7:0] m;
		m = p;
		if (mode_reg == mps_pkg::MODE_TEXT) begin
			if (((p >= 8'h41 && p <= 8'h5A) || (p >= 8'h61 && p <= 8'h7A)) && $urandom_range(0, 1))
				m = m ^ 8'h20;
			if ($urandom_range(0, 1)) m = m | 8'h80;
		end
		return m;
	endfunction

	// copy the pattern a short way past where the next scan begins
	function automatic void planted_search();
		int n;
		int first;
		int limit;
		int off;
		int at;
		int start;
		n = pattern_span();
		start = $urandom_range(0, 65535);
		first = hit_valid ? int'(hit_addr) + 1 : start;
		limit = MEM_BYTES - n;
		off = $urandom_range(0, 40);
		at = (first + off > limit) ? off : first + off;
		for (int i = 0; i < n; i++) send_mem(at + i, int'(disguise(pat_img[7'(i)])));
		send_search(start);
	endfunction

	task automatic wait_idle(input int extra);
		do @(negedge clk);
		while (items_to_send.size() != 0 || in_valid || search_answers.size() != 0);
		repeat (extra) @(negedge clk);
	endtask

	task automatic write_reg(input logic [mps_pkg::CFG_IDX_W-1:0] idx,
			input logic [mps_pkg::CFG_DAT_W-1:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk);
		while (!cfg_ready);
		cfg_valid <= 1'b0;
		if (idx == mps_pkg::CFG_MATCH_MODE) mode_reg = val[0];
		else if (idx == mps_pkg::CFG_PATTERN_LENGTH) pat_len_reg = val;
		@(negedge clk);
	endtask

	initial begin : stimulus
		int         k;
		int         s;
		int         noise;
		int         seg_base;
		int         seg_searches;
		int         unplanted_left;
		logic [7:0] marker;
		logic [7:0] len_val;
		logic       mode_val;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		write_reg(mps_pkg::CFG_MATCH_MODE, {7'd0, mps_pkg::MODE_EXACT});
		write_reg(mps_pkg::CFG_PATTERN_LENGTH, 8'd1);

		// every byte of both stores gets written before any search
		for (k = 0; k < MEM_BYTES; k++) send_mem(k, $urandom_range(0, 255));
		for (k = 0; k < PAT_SLOTS; k++) send_pat(k, $urandom_range(0, 255));
		wait_idle(0);

		send_idle_pct = 25;
		recv_idle_pct = 85;

		// match at the top address, then a scan that wraps around to the bottom of the memory
		marker = 8'($urandom_range(0, 255));
		send_mem(0, 8'h00);
		send_pat(127, 8'hFF);
		send_pat(0, int'(marker));
		send_mem(5, int'(marker));
		send_mem(16'hFFFF, int'(marker));
		send_search(16'hFFFF);
		send_search($urandom_range(0, 65535));

		// zero length: no result; unused opcode ignored
		wait_idle(SETTLE_CYCLES);
		write_reg(mps_pkg::CFG_PATTERN_LENGTH, 8'd0);
		send_search($urandom_range(0, 65535));
		send(random_item(OP_UNUSED));

		// oversized length in text mode with a high pattern byte: a full miss
		wait_idle(SETTLE_CYCLES);
		write_reg(mps_pkg::CFG_MATCH_MODE, {7'd0, mps_pkg::MODE_TEXT});
		write_reg(mps_pkg::CFG_PATTERN_LENGTH, 8'd200);
		send_pat(0, 8'hC1);
		send_search(16'h0000);

		// text compare: case folding and bit 7 masking in memory
		wait_idle(SETTLE_CYCLES);
		write_reg(mps_pkg::CFG_PATTERN_LENGTH, 8'd3);
		send_pat(0, 8'h61);
		send_pat(1, 8'h5A);
		send_pat(2, 8'h3F);
		send_mem(16'h1000, 8'hC1);
		send_mem(16'h1001, 8'h7A);
		send_mem(16'h1002, 8'hBF);
		send_search(16'h0FF0);

		// exact compare resumes past the remembered match
		wait_idle(SETTLE_CYCLES);
		write_reg(mps_pkg::CFG_MATCH_MODE, {7'd0, mps_pkg::MODE_EXACT});
		send_mem(16'h1008, 8'h61);
		send_mem(16'h1009, 8'h5A);
		send_mem(16'h100A, 8'h3F);
		send_search($urandom_range(0, 65535));

		for (int third = 0; third < 3; third++) begin
			send_idle_pct = (third == 0) ? 25 : (third == 1) ? 85 : 0;
			recv_idle_pct = (third == 0) ? 85 : (third == 1) ? 25 : 0;
			unplanted_left = 1;
			for (int seg = 0; seg < 4; seg++) begin
				s = third * 4 + seg;
				if (s == 1) begin
					mode_val = mps_pkg::MODE_EXACT;
					len_val = 8'd128;
				end else if (s == 9) begin
					mode_val = mps_pkg::MODE_TEXT;
					len_val = 8'd128;
				end else begin
					mode_val = $urandom_range(0, 1) ? mps_pkg::MODE_TEXT : mps_pkg::MODE_EXACT;
					if (s == 6) len_val = 8'd1;
					else if ($urandom_range(0, 4) == 0) len_val = 8'($urandom_range(9, 24));
					else len_val = 8'($urandom_range(1, 8));
				end
				wait_idle(SETTLE_CYCLES);
				write_reg(mps_pkg::CFG_MATCH_MODE, {7'd0, mode_val});
				write_reg(mps_pkg::CFG_PATTERN_LENGTH, len_val);
				for (k = 0; k < pattern_span(); k++) send_pat(k, int'(pattern_byte()));
				seg_base = useful_items;
				seg_searches = 0;
				while (useful_items - seg_base < SEGMENT_ITEMS || seg_searches < 2) begin
					noise = $urandom_range(0, 3);
					repeat (noise) begin
						k = $urandom_range(0, 19);
						if (k < 12) send_mem($urandom_range(0, 65535), $urandom_range(0, 255));
						else if (k < 17) send_pat($urandom_range(0, 127), int'(pattern_byte()));
						else send(random_item(OP_UNUSED));
					end
					wait_idle(0);
					if (unplanted_left > 0 && $urandom_range(0, 15) == 0) begin
						unplanted_left--;
						send_search($urandom_range(0, 65535));
					end else begin
						planted_search();
					end
					seg_searches++;
				end
			end
		end

		wait_idle(SETTLE_CYCLES);
		if (mismatch_count == 0) $display("No mismatches found");
		else $display("Mismatches found");
		$finish;
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
				quiet = 0;
			else
				quiet++;
		end
		$display("Mismatches found");
		$finish;
	end

endmodule
